@@ sv/wft_pkg.sv @@
`timescale 1ns / 1ps
package wft_pkg;
  localparam int MaxWords = 64;
  localparam int MaxWordLen = 32;
  localparam int EntryW = $clog2(MaxWords);
  localparam int LetW = $clog2(MaxWordLen);
  localparam int LenW = $clog2(MaxWordLen + 1);
  localparam int UsedW = $clog2(MaxWords + 1);
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic ActPush = 1'b0;
  localparam logic ActRead = 1'b1;
  localparam logic KindWord = 1'b0;
  localparam logic KindLetter = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  entry_index;
    logic [15:0] word_count;
    logic [7:0]  letter;
    logic        is_new;
    logic        too_long_seen;
    logic        table_full;
    logic        last;
  } out_item_t;
endpackage

@@ sv/wft_if.sv @@
`timescale 1ns / 1ps
interface wft_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
  modport monitor(input valid, input data, input ready);
endinterface

@@ sv/word_frequency_table_top.sv @@
`timescale 1ns / 1ps
// Word frequency counter. A letter byte gives no result. A word-ending byte
// scans the stored entries through a single compare unit that reads the letter
// memory: each entry passes through S_ELEN and S_CMP, and through S_CMPD once per
// letter compared when the lengths agree. A hit then gives its result from S_HIT;
// a new word is copied in at one letter per cycle. A read passes through S_RD,
// S_RDD and S_CNT before S_OUT gives its first letter, and through S_CNT and S_OUT
// for each further letter; S_OUT waits while an earlier result is still untaken.
// Input is not ready while an item is in progress; results leave through one output register.
module word_frequency_table_top import wft_pkg::*; (
  input logic clk,
  input logic rst,
  wft_if.sink   in_ch,
  wft_if.source out_ch
);
  localparam logic [3:0] S_IDLE = 4'd0, S_ELEN = 4'd1, S_CMP = 4'd2, S_CMPD = 4'd3,
    S_COPY = 4'd4, S_HIT = 4'd5, S_RD = 4'd6, S_RDD = 4'd7, S_OUT = 4'd8,
    S_CNT = 4'd9;

  logic [3:0] state;
  logic [7:0] word_letters [MaxWordLen];
  logic [LenW-1:0] word_length;
  logic [7:0] ent_mem [MaxWords*MaxWordLen];
  logic [LenW-1:0] len_mem [MaxWords];
  logic [15:0] cnt_mem [MaxWords];
  logic [UsedW-1:0] entries_used;
  logic full_flag, overlong_flag;
  logic [EntryW-1:0] e;
  logic [LenW-1:0] i;
  logic [7:0] mem_q;
  logic [LenW-1:0] len_q;
  logic [15:0] cnt_q;
  logic [EntryW-1:0] rd_idx;
  logic [LenW-1:0] rd_len;
  logic [15:0] rd_cnt;
  out_item_t res;
  logic res_v;
  logic [7:0] lc;
  logic is_let;

  always_comb begin
    lc = in_ch.data.text_byte;
    if (lc >= 8'h41 && lc <= 8'h5A) lc = lc + 8'd32;
    is_let = lc >= 8'h61 && lc <= 8'h7A;
  end

  assign in_ch.ready = (state == S_IDLE) && !res_v;
  assign out_ch.valid = res_v;
  assign out_ch.data = res;

  logic [EntryW+LetW-1:0] addr;
  assign addr = {e, i[LetW-1:0]};

  always_ff @(posedge clk) begin
    mem_q <= ent_mem[addr];
    len_q <= len_mem[e];
    cnt_q <= cnt_mem[e];
    if (state == S_COPY) ent_mem[addr] <= word_letters[i[LetW-1:0]];
    if (state == S_COPY && i == word_length - 1'b1) begin
      len_mem[e] <= word_length;
      cnt_mem[e] <= 16'd1;
    end
    if (state == S_HIT && cnt_q != CountMax) cnt_mem[e] <= cnt_q + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; res_v <= 1'b0; word_length <= '0; entries_used <= '0;
      full_flag <= 1'b0; overlong_flag <= 1'b0; e <= '0; i <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) res_v <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          if (in_ch.data.action == ActRead) begin
            rd_idx <= in_ch.data.read_index[EntryW-1:0];
            e <= in_ch.data.read_index[EntryW-1:0];
            i <= '0;
            if ({1'b0, in_ch.data.read_index} >= (7)'(entries_used)) begin
              res <= '{KindLetter, in_ch.data.read_index, 16'd0, 8'd0, 1'b0,
                       overlong_flag, full_flag, 1'b1};
              res_v <= 1'b1;
            end else state <= S_RD;
          end else if (!full_flag) begin
            if (is_let) begin
              if (word_length < (LenW)'(MaxWordLen)) begin
                word_letters[word_length[LetW-1:0]] <= lc;
                word_length <= word_length + 1'b1;
              end
            end else if (word_length != '0) begin
              if (word_length == (LenW)'(MaxWordLen)) begin
                overlong_flag <= 1'b1; word_length <= '0;
                res <= '{KindWord, 6'd0, 16'd0, 8'd0, 1'b0, 1'b1, full_flag, 1'b1};
                res_v <= 1'b1;
              end else begin
                e <= '0; i <= '0;
                state <= (entries_used == '0) ? S_COPY : S_ELEN;
              end
            end
          end
        end
        S_ELEN: state <= S_CMP;  // memories read entry e, letter 0
        S_CMP: begin
          if (len_q == word_length) begin
            state <= S_CMPD; i <= i + 1'b1;
          end else if ((UsedW)'(e) + 1'b1 == entries_used) begin
            e <= (EntryW)'(entries_used); i <= '0; state <= S_COPY;
          end else begin
            e <= e + 1'b1; state <= S_ELEN;
          end
        end
        S_CMPD: begin
          // mem_q holds letter i-1 of entry e.
          if (mem_q != word_letters[LetW'(i - 1'b1)]) begin
            i <= '0;
            if ((UsedW)'(e) + 1'b1 == entries_used) begin
              e <= (EntryW)'(entries_used); state <= S_COPY;
            end else begin
              e <= e + 1'b1; state <= S_ELEN;
            end
          end else if (i == word_length) state <= S_HIT;
          else i <= i + 1'b1;
        end
        S_HIT: begin
          res <= '{KindWord, 6'(e), (cnt_q == CountMax) ? cnt_q : cnt_q + 16'd1,
                   8'd0, 1'b0, overlong_flag, full_flag, 1'b1};
          res_v <= 1'b1; word_length <= '0; state <= S_IDLE;
        end
        S_COPY: begin
          if (i == word_length - 1'b1) begin
            entries_used <= entries_used + 1'b1;
            if (entries_used + 1'b1 == (UsedW)'(MaxWords)) full_flag <= 1'b1;
            res <= '{KindWord, 6'(e), 16'd1, 8'd0, 1'b1, overlong_flag,
                     (entries_used + 1'b1 == (UsedW)'(MaxWords)), 1'b1};
            res_v <= 1'b1; word_length <= '0; state <= S_IDLE;
          end else i <= i + 1'b1;
        end
        S_RD: state <= S_RDD;
        S_RDD: begin rd_len <= len_q; rd_cnt <= cnt_q; state <= S_CNT; end
        S_CNT: state <= S_OUT;  // mem_q holds letter i by S_OUT
        S_OUT: if (!res_v || out_ch.ready) begin
          res <= '{KindLetter, 6'(rd_idx), rd_cnt, mem_q, 1'b0, overlong_flag,
                   full_flag, (i + 1'b1 == rd_len)};
          res_v <= 1'b1;
          if (i + 1'b1 == rd_len) state <= S_IDLE;
          else begin i <= i + 1'b1; state <= S_CNT; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ent: assert property (@(posedge clk) disable iff (rst)
    entries_used <= (UsedW)'(MaxWords)) else $error("entry count overflow");
  a_full: assert property (@(posedge clk) disable iff (rst)
    full_flag == (entries_used == (UsedW)'(MaxWords))) else $error("full flag");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !res_v) else $error("ready while result pending");
`endif
endmodule

@@ dv/word_tally_checker.sv @@
`timescale 1ns / 1ps
module word_tally_checker import wft_pkg::*; (
  input logic clk,
  input logic rst,
  wft_if.monitor in_mon,
  wft_if.monitor out_mon,
  output int errors,
  output int pending
);
  // Own copy of the table state.
  logic [7:0] cur_word[MaxWordLen];
  int cur_len;
  logic [7:0] stored_letters[MaxWords][MaxWordLen];
  int stored_len[MaxWords];
  logic [15:0] stored_count[MaxWords];
  int used;
  logic full_seen;
  logic overlong_seen;
  out_item_t expected_results[$];

  assign pending = expected_results.size();

  function automatic out_item_t mk(logic kind, logic [5:0] idx, logic [15:0] cnt,
                                   logic [7:0] ltr, logic nw, logic lst);
    out_item_t r;
    r.kind = kind;
    r.entry_index = idx;
    r.word_count = cnt;
    r.letter = ltr;
    r.is_new = nw;
    r.too_long_seen = overlong_seen;
    r.table_full = full_seen;
    r.last = lst;
    return r;
  endfunction

  task automatic tally_item(in_item_t it);
    logic [7:0] b;
    int hit;
    int ri;
    b = it.text_byte;
    hit = -1;
    ri = it.read_index;
    if (it.action == ActRead) begin
      if (ri >= used || stored_len[ri] == 0) begin
        expected_results.push_back(mk(KindLetter, it.read_index, 16'd0, 8'd0, 1'b0, 1'b1));
      end else begin
        for (int i = 0; i < stored_len[ri]; i++)
          expected_results.push_back(mk(KindLetter, it.read_index, stored_count[ri],
                                        stored_letters[ri][i], 1'b0, i + 1 == stored_len[ri]));
      end
      return;
    end
    if (full_seen) return;
    if (b >= "A" && b <= "Z") b = b + 8'd32;
    if (b >= "a" && b <= "z") begin
      if (cur_len < MaxWordLen) begin
        cur_word[cur_len] = b;
        cur_len++;
      end
      return;
    end
    if (cur_len == 0) return;
    if (cur_len >= MaxWordLen) begin
      overlong_seen = 1'b1;
      cur_len = 0;
      expected_results.push_back(mk(KindWord, 6'd0, 16'd0, 8'd0, 1'b0, 1'b1));
      return;
    end
    for (int e = 0; e < used && hit < 0; e++) begin
      if (stored_len[e] == cur_len) begin
        hit = e;
        for (int i = 0; i < cur_len; i++)
          if (stored_letters[e][i] != cur_word[i]) hit = -1;
      end
    end
    if (hit >= 0) begin
      if (stored_count[hit] != CountMax) stored_count[hit]++;
      expected_results.push_back(mk(KindWord, hit[5:0], stored_count[hit], 8'd0,
                                    1'b0, 1'b1));
    end else begin
      for (int i = 0; i < cur_len; i++) stored_letters[used][i] = cur_word[i];
      stored_len[used] = cur_len;
      stored_count[used] = 16'd1;
      used++;
      if (used >= MaxWords) full_seen = 1'b1;
      expected_results.push_back(mk(KindWord, 6'(used - 1), 16'd1, 8'd0, 1'b1, 1'b1));
    end
    cur_len = 0;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cur_len = 0;
      used = 0;
      full_seen = 1'b0;
      overlong_seen = 1'b0;
      errors = 0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_mon.data);
        end else begin
          want = expected_results.pop_front();
          if (want !== out_mon.data) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, out_mon.data);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) tally_item(in_mon.data);
    end
  end
endmodule

@@ dv/tb_word_frequency_table_top.sv @@
`timescale 1ns / 1ps
module tb_word_frequency_table_top;
  import wft_pkg::*;

  logic clk;
  logic rst;
  int errors;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int quiet_cycles;
  logic [7:0] word_pool[8][6];
  int word_pool_len[8];

  wft_if #(.payload_t(in_item_t)) in_ch ();
  wft_if #(.payload_t(out_item_t)) out_ch ();

  word_frequency_table_top u_top (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  word_tally_checker u_chk (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
                            .errors(errors), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic offer(logic act, logic [7:0] b, logic [5:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{action: act, text_byte: b, read_index: idx};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) offer(ActPush, s[i], 6'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int w;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        w = $urandom_range(7);
        for (int i = 0; i < word_pool_len[w]; i++)
          offer(ActPush, $urandom_range(1) ? word_pool[w][i] : word_pool[w][i] - 8'd32,
                6'($urandom));
        offer(ActPush, $urandom_range(1) ? " " : 8'($urandom_range(123, 255)), 6'($urandom));
      end else if (r < 75) begin
        offer(ActRead, 8'($urandom), 6'($urandom_range(9)));
      end else if (r < 85) begin
        offer(ActRead, 8'($urandom), 6'($urandom));
      end else begin
        offer(ActPush, 8'($urandom), 6'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    send_idle_pct = 28;
    recv_idle_pct = 67;
    hold_cycles = 0;
    for (int w = 0; w < 8; w++) begin
      word_pool_len[w] = 1 + (w % 6);
      for (int i = 0; i < 6; i++) word_pool[w][i] = 8'("a" + ((w * 3 + i) % 5));
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty words, mixed case, hits, too-long word, reads of used
    // and unused entries.
    offer(ActRead, 8'hFF, 6'd0);
    push_text(". Cat cAT dog,zZ@[`{");
    push_text("abcdefghijklmnopqrstuvwxyzabcdef ");
    push_text("abcdefghijklmnopqrstuvwxyzabcde ");
    offer(ActRead, 8'h00, 6'd0);
    offer(ActRead, 8'h00, 6'd3);
    offer(ActRead, 8'h00, 6'd63);
    drain();

    // The receiver holds off while the sender keeps going.
    hold_cycles = 300;
    random_phase(7);
    drain();

    send_idle_pct = 67;
    recv_idle_pct = 28;
    random_phase(7);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(7);

    // A last word, then reads of an unused and a used entry.
    push_text("xyz ");
    offer(ActRead, 8'h00, 6'd63);
    offer(ActRead, 8'h00, 6'd1);
    drain();

    if (errors == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

@@ files.f @@
sv/wft_pkg.sv
sv/wft_if.sv
sv/word_frequency_table_top.sv
dv/word_tally_checker.sv
dv/tb_word_frequency_table_top.sv
